[src/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int          KEPT_BITS = 24;
    localparam logic [23:0] KEPT_MAX  = 24'hFFFFFF;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_SKIP = 5'b00001,
        PH_SIZE = 5'b00010,
        PH_TOLF = 5'b00100,
        PH_DATA = 5'b01000,
        PH_STOP = 5'b10000
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    typedef struct packed {
        logic                 keep;
        logic [7:0]           data;
        logic                 body_end;
        logic                 stopped;
        logic [KEPT_BITS-1:0] out_count;
    } result_t;

    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

[src/hcbd_if.sv]
// ----------------------------------------------------------------------------
// hcbd_if
// Valid/ready channels of the chunked body decoder: raw bytes in, results out.
// ----------------------------------------------------------------------------
interface hcbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       body_last;

    modport source (output valid, output in_byte, output body_last, input ready);
    modport sink   (input valid, input in_byte, input body_last, output ready);
endinterface

interface hcbd_result_if;
    logic        valid;
    logic        ready;
    logic        keep;
    logic [7:0]  data;
    logic        body_end;
    logic        stopped;
    logic [23:0] out_count;

    modport source (output valid, output keep, output data, output body_end,
                    output stopped, output out_count, input ready);
    modport sink   (input valid, input keep, input data, input body_end,
                    input stopped, input out_count, output ready);
endinterface

[src/hcbd_step.sv]
// ----------------------------------------------------------------------------
// hcbd_step
// Next-state and result logic for one body byte.
// ----------------------------------------------------------------------------
module hcbd_step #(
    parameter int COUNT_BITS = 24
) (
    input  hcbd_pkg::phase_t                    phase,
    input  logic [COUNT_BITS-1:0]               size_acc,
    input  logic                                digit_seen,
    input  logic [COUNT_BITS-1:0]               bytes_left,
    input  logic [hcbd_pkg::KEPT_BITS-1:0]      kept_total,
    input  logic [7:0]                          in_byte,
    input  logic                                body_last,
    output hcbd_pkg::phase_t                    phase_next,
    output logic [COUNT_BITS-1:0]               size_acc_next,
    output logic                                digit_seen_next,
    output logic [COUNT_BITS-1:0]               bytes_left_next,
    output logic [hcbd_pkg::KEPT_BITS-1:0]      kept_total_next,
    output hcbd_pkg::result_t                   result
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    hcbd_pkg::hex_digit_t  hex;
    logic [COUNT_BITS-1:0] acc_shifted;
    logic [COUNT_BITS-1:0] left_dec;
    hcbd_pkg::phase_t      ph;
    logic [COUNT_BITS-1:0] acc;
    logic                  seen;
    logic [COUNT_BITS-1:0] left;
    logic [hcbd_pkg::KEPT_BITS-1:0] kept;
    logic                  keep;

    assign hex = hcbd_pkg::hex_value(in_byte);

    // acc*16 + d, saturated when any of the top nibble would shift out
    always_comb
    begin
        if (size_acc[COUNT_BITS-1 -: 4] != 4'd0)
            acc_shifted = CNT_MAX;
        else
            acc_shifted = {size_acc[COUNT_BITS-5:0], hex.val};
    end

    assign left_dec = (bytes_left != '0) ? bytes_left - 1'b1 : '0;

    always_comb
    begin
        ph   = phase;
        acc  = size_acc;
        seen = digit_seen;
        left = bytes_left;
        kept = kept_total;
        keep = 1'b0;

        unique case (phase)
            hcbd_pkg::PH_SIZE:
            begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    // judge the size line now
                    if (!digit_seen || size_acc == '0)
                        ph = hcbd_pkg::PH_STOP;
                    else begin
                        left = size_acc;
                        ph   = hcbd_pkg::PH_DATA;
                    end
                    acc  = '0;
                    seen = 1'b0;
                end
                else if (in_byte == hcbd_pkg::CH_CR || in_byte == hcbd_pkg::CH_SEMI)
                    ph = hcbd_pkg::PH_TOLF;
                else if (hex.ok) begin
                    acc  = acc_shifted;
                    seen = 1'b1;
                end
            end
            hcbd_pkg::PH_TOLF:
            begin
                if (in_byte == hcbd_pkg::CH_LF) begin
                    if (!digit_seen || size_acc == '0)
                        ph = hcbd_pkg::PH_STOP;
                    else begin
                        left = size_acc;
                        ph   = hcbd_pkg::PH_DATA;
                    end
                    acc  = '0;
                    seen = 1'b0;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                keep = 1'b1;
                if (kept_total != hcbd_pkg::KEPT_MAX)
                    kept = kept_total + 1'b1;
                left = left_dec;
                if (left_dec == '0)
                    ph = hcbd_pkg::PH_SKIP;
            end
            hcbd_pkg::PH_STOP:
            begin
                // drop everything up to the end of the body
            end
            default:
            begin
                // skip line ends; stray codes behave the same
                acc  = '0;
                seen = 1'b0;
                if (in_byte == hcbd_pkg::CH_CR || in_byte == hcbd_pkg::CH_LF)
                    ph = hcbd_pkg::PH_SKIP;
                else if (in_byte == hcbd_pkg::CH_SEMI)
                    ph = hcbd_pkg::PH_TOLF;
                else begin
                    ph = hcbd_pkg::PH_SIZE;
                    if (hex.ok) begin
                        acc  = {{(COUNT_BITS-4){1'b0}}, hex.val};
                        seen = 1'b1;
                    end
                end
            end
        endcase
    end

    assign result.keep      = keep;
    assign result.data      = keep ? in_byte : 8'd0;
    assign result.body_end  = body_last;
    assign result.stopped   = (ph == hcbd_pkg::PH_STOP);
    assign result.out_count = kept;

    // last byte of the body returns everything to the start
    assign phase_next      = body_last ? hcbd_pkg::PH_SKIP : ph;
    assign size_acc_next   = body_last ? '0 : acc;
    assign digit_seen_next = body_last ? 1'b0 : seen;
    assign bytes_left_next = body_last ? '0 : left;
    assign kept_total_next = body_last ? '0 : kept;

endmodule

[src/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips HTTP chunked transfer framing from a body, one byte per item.
// ----------------------------------------------------------------------------
// Each byte passes the input register, then the result register, before its
// result is offered on the result channel.
// Throughput: one byte per cycle while results are taken; parser state updates in a single step.
// A stalled result holds the result register; one more byte waits in the
// input register, and input ready drops only when both are full.
// Reset: asynchronous, active low; parser returns to skipping line ends with
// all counters cleared, and both register stages are emptied.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int COUNT_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hcbd_byte_if.sink             body,
    hcbd_result_if.source         result
);

    // Input register stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       body_last_reg;

    // Parser state
    hcbd_pkg::phase_t               phase_reg;
    hcbd_pkg::phase_t               phase_next;
    logic [COUNT_BITS-1:0]          size_acc_reg;
    logic [COUNT_BITS-1:0]          size_acc_next;
    logic                           digit_seen_reg;
    logic                           digit_seen_next;
    logic [COUNT_BITS-1:0]          bytes_left_reg;
    logic [COUNT_BITS-1:0]          bytes_left_next;
    logic [hcbd_pkg::KEPT_BITS-1:0] kept_total_reg;
    logic [hcbd_pkg::KEPT_BITS-1:0] kept_total_next;

    // Result register stage
    logic              out_valid_reg;
    logic              out_valid_next;
    hcbd_pkg::result_t step_result;
    hcbd_pkg::result_t out_reg;

    logic advance;
    logic take_in;

    // Move the held byte into the result register when that slot is free
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign body.ready = !in_valid_reg || advance;
    assign take_in = body.valid && body.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    hcbd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .phase           (phase_reg),
        .size_acc        (size_acc_reg),
        .digit_seen      (digit_seen_reg),
        .bytes_left      (bytes_left_reg),
        .kept_total      (kept_total_reg),
        .in_byte         (in_byte_reg),
        .body_last       (body_last_reg),
        .phase_next      (phase_next),
        .size_acc_next   (size_acc_next),
        .digit_seen_next (digit_seen_next),
        .bytes_left_next (bytes_left_next),
        .kept_total_next (kept_total_next),
        .result          (step_result)
    );

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= hcbd_pkg::PH_SKIP;
            size_acc_reg   <= '0;
            digit_seen_reg <= 1'b0;
            bytes_left_reg <= '0;
            kept_total_reg <= '0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg      <= phase_next;
                size_acc_reg   <= size_acc_next;
                digit_seen_reg <= digit_seen_next;
                bytes_left_reg <= bytes_left_next;
                kept_total_reg <= kept_total_next;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (take_in) begin
            in_byte_reg   <= body.in_byte;
            body_last_reg <= body.body_last;
        end
        if (advance)
            out_reg <= step_result;
    end

    assign result.valid     = out_valid_reg;
    assign result.keep      = out_reg.keep;
    assign result.data      = out_reg.data;
    assign result.body_end  = out_reg.body_end;
    assign result.stopped   = out_reg.stopped;
    assign result.out_count = out_reg.out_count;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunked body decoder. Streams directed and
// random HTTP bodies (well-formed chunk framing, broken framing and noise)
// through the byte channel under changing back-pressure, predicts every
// result item in a local parser model and compares each field on arrival.
// ----------------------------------------------------------------------------
module tb;

    import hcbd_pkg::*;

    localparam int CNT_BITS = 24;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } body_item_t;

    logic clk;
    logic rst_n;

    hcbd_byte_if   in_ch();
    hcbd_result_if out_ch();

    http_chunked_body_decoder #(
        .COUNT_BITS(CNT_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (in_ch),
        .result (out_ch)
    );

    // ------------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------------
    body_item_t  body_bytes[$];     // items waiting for the driver
    logic [7:0]  frame_q[$];        // body under construction
    result_t     decoded_q[$];      // predicted results, oldest first

    int          total_sent  = 0;   // items handed to the driver
    int          n_results   = 0;   // result items accepted from the block
    int          mismatches  = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    logic        in_taken    = 1'b0;
    body_item_t  nxt_item;
    result_t     want;

    // ------------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------------
    phase_t                parse_ph   = PH_SKIP;
    logic [CNT_BITS-1:0]   sz_acc     = '0;
    logic                  sz_seen    = 1'b0;
    logic [CNT_BITS-1:0]   chunk_left = '0;
    logic [KEPT_BITS-1:0]  kept_cnt   = '0;

    // Map an ASCII character to {valid, nibble}.
    function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    // Shift one hex digit into the size, saturating at the counter maximum.
    // Non-hex characters leave the size and the digit flag alone.
    function automatic void take_digit(input logic [7:0] c);
        logic [4:0]          h;
        logic [CNT_BITS+3:0] grown;
        h = hex_digit_of(c);
        if (h[4]) begin
            grown = {sz_acc, h[3:0]};
            if (grown[CNT_BITS+3:CNT_BITS] != 4'd0)
                sz_acc = '1;
            else
                sz_acc = grown[CNT_BITS-1:0];
            sz_seen = 1'b1;
        end
    endfunction

    // Judge a finished size line: no digit or zero stops the body,
    // anything else opens a chunk of that many payload bytes.
    function automatic void close_size_line();
        if (!sz_seen || sz_acc == '0) begin
            parse_ph = PH_STOP;
        end
        else begin
            chunk_left = sz_acc;
            parse_ph   = PH_DATA;
        end
        sz_acc  = '0;
        sz_seen = 1'b0;
    endfunction

    // Advance the parser model by one body byte and return its result item.
    function automatic result_t decode_step(input logic [7:0] c, input logic last);
        result_t r;
        logic    keep;
        keep = 1'b0;
        case (parse_ph)
            PH_SIZE: begin
                if (c == CH_LF)
                    close_size_line();
                else if (c == CH_CR || c == CH_SEMI)
                    parse_ph = PH_TOLF;
                else
                    take_digit(c);
            end
            PH_TOLF: begin
                if (c == CH_LF)
                    close_size_line();
            end
            PH_DATA: begin
                keep = 1'b1;
                if (kept_cnt != KEPT_MAX)
                    kept_cnt = kept_cnt + 1'b1;
                if (chunk_left != '0)
                    chunk_left = chunk_left - 1'b1;
                if (chunk_left == '0)
                    parse_ph = PH_SKIP;
            end
            PH_STOP: begin
            end
            default: begin
                // Skipping line ends: a semicolon opens an extension, any other byte opens a size line.
                sz_acc  = '0;
                sz_seen = 1'b0;
                if (c == CH_CR || c == CH_LF) begin
                    parse_ph = PH_SKIP;
                end
                else if (c == CH_SEMI) begin
                    parse_ph = PH_TOLF;
                end
                else begin
                    take_digit(c);
                    parse_ph = PH_SIZE;
                end
            end
        endcase

        r.keep      = keep;
        r.data      = keep ? c : 8'h00;
        r.body_end  = last;
        r.stopped   = (parse_ph == PH_STOP);
        r.out_count = kept_cnt;

        // The final byte of a body returns the parser to its reset state.
        if (last) begin
            parse_ph   = PH_SKIP;
            sz_acc     = '0;
            sz_seen    = 1'b0;
            chunk_left = '0;
            kept_cnt   = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and time limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive every block input to a known value from time zero.
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.body_last = 1'b0;
        out_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: present a new item at the falling edge once the previous one
    // was taken, or leave the channel idle at the current sender idle rate.
    // The result ready is redrawn every cycle at the receiver idle rate.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_taken) begin
            if (body_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt_item        = body_bytes.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.in_byte   <= nxt_item.b;
                in_ch.body_last <= nxt_item.last;
            end
            else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, check an accepted result against the
    // oldest prediction, then predict the result of an accepted body byte.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (decoded_q.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    mismatches++;
                end
                else begin
                    want = decoded_q.pop_front();
                    check_field("keep",      want.keep,      out_ch.keep);
                    check_field("data",      want.data,      out_ch.data);
                    check_field("body_end",  want.body_end,  out_ch.body_end);
                    check_field("stopped",   want.stopped,   out_ch.stopped);
                    check_field("out_count", want.out_count, out_ch.out_count);
                end
            end
            if (in_ch.valid && in_ch.ready)
                decoded_q.push_back(decode_step(in_ch.in_byte, in_ch.body_last));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic last);
        body_bytes.push_back('{b: b, last: last});
        total_sent++;
    endtask

    // Hand the frame under construction to the driver, marking its final byte.
    task automatic flush_frame();
        foreach (frame_q[i])
            add_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + n;                       // '0'..'9'
        return (upper ? 8'h41 : 8'h61) + n - 8'd10; // 'A'..'F' or 'a'..'f'
    endfunction

    // Append a size in hex, no leading zeros, random letter case.
    task automatic emit_size(input logic [31:0] s);
        bit started;
        started = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (s[i*4 +: 4] != 4'd0 || started || i == 0) begin
                frame_q.push_back(hex_char(s[i*4 +: 4], $urandom_range(1)));
                started = 1'b1;
            end
        end
    endtask

    // Close a size line in one of the ways a sender may: extension, CR LF,
    // bare LF, or CR followed by junk that is skipped up to the LF.
    task automatic emit_line_end();
        case ($urandom_range(3))
            0: begin
                frame_q.push_back(CH_SEMI);
                repeat ($urandom_range(0, 6))
                    frame_q.push_back(8'($urandom_range(8'h3D, 8'h7A)));
                frame_q.push_back(CH_CR);
                frame_q.push_back(CH_LF);
            end
            1: begin
                frame_q.push_back(CH_CR);
                frame_q.push_back(CH_LF);
            end
            2: frame_q.push_back(CH_LF);
            default: begin
                frame_q.push_back(CH_CR);
                repeat ($urandom_range(1, 3))
                    frame_q.push_back(8'($urandom_range(8'h20, 8'h7E) | 8'h40));
                frame_q.push_back(CH_LF);
            end
        endcase
    endtask

    // One chunked body: a few chunks with random payload, a zero chunk,
    // optional trailer and garbage after the stop. Some bodies carry an
    // oversized chunk or are cut short anywhere.
    task automatic gen_chunked_body();
        int         n_chunks;
        int         s;
        int         cut;
        bit         big;
        frame_q.delete();
        n_chunks = $urandom_range(1, 4);
        for (int k = 0; k < n_chunks; k++) begin
            if ($urandom_range(7) == 0)
                frame_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
            big = ($urandom_range(19) == 0);
            if (big) begin
                // Seven or more digits with a nonzero lead: saturates the size.
                frame_q.push_back(hex_char(4'($urandom_range(1, 15)), $urandom_range(1)));
                repeat ($urandom_range(6, 8))
                    frame_q.push_back(hex_char(4'($urandom_range(15)), $urandom_range(1)));
                s = $urandom_range(1, 8);
            end
            else begin
                s = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
                if ($urandom_range(7) == 0)
                    frame_q.push_back(8'h30);
                emit_size(s);
            end
            emit_line_end();
            repeat (s)
                frame_q.push_back(8'($urandom_range(255)));
            if (big) begin
                // The body ends inside the oversized chunk.
                flush_frame();
                return;
            end
            if ($urandom_range(3) != 0)
                frame_q.push_back(CH_CR);
            frame_q.push_back(CH_LF);
        end
        frame_q.push_back(8'h30);
        if ($urandom_range(3) == 0)
            frame_q.push_back(8'h30);
        emit_line_end();
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 6))
                frame_q.push_back(8'($urandom_range(255)));
        end
        frame_q.push_back(CH_CR);
        frame_q.push_back(CH_LF);
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, frame_q.size());
            frame_q = frame_q[0:cut-1];
        end
        flush_frame();
    endtask

    // Noise body: bytes biased toward framing characters and hex digits.
    task automatic gen_noise();
        repeat ($urandom_range(1, 16)) begin
            case ($urandom_range(4))
                0: frame_q.push_back(CH_CR);
                1: frame_q.push_back(CH_LF);
                2: frame_q.push_back(CH_SEMI);
                3: frame_q.push_back(hex_char(4'($urandom_range(15)), $urandom_range(1)));
                default: frame_q.push_back(8'($urandom_range(255)));
            endcase
        end
        flush_frame();
    endtask

    task automatic fill_random(input int n);
        int start;
        start = total_sent;
        while (total_sent - start < n) begin
            if ($urandom_range(9) < 7)
                gen_chunked_body();
            else
                gen_noise();
        end
    endtask

    // Hold off until every item handed out has produced its result.
    task automatic wait_drained();
        while (n_results < total_sent)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        wait (rst_n === 1'b1);

        // Directed: byte extremes as one-byte bodies.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        // Semicolon opening the size line: no digit, stop at its LF,
        // then drop the rest of the body.
        add_byte(CH_SEMI, 1'b0);
        add_byte(CH_LF,   1'b0);
        add_byte(8'h41,   1'b1);
        // Line ends skipped, LF right after the digit, payload extremes,
        // then a zero chunk closing the body.
        add_byte(CH_CR,   1'b0);
        add_byte(CH_LF,   1'b0);
        add_byte(8'h32,   1'b0);
        add_byte(CH_LF,   1'b0);
        add_byte(8'hFF,   1'b0);
        add_byte(8'h00,   1'b0);
        add_byte(8'h30,   1'b0);
        add_byte(CH_CR,   1'b0);
        add_byte(CH_LF,   1'b1);
        // Oversized mixed-case size saturates; body ends inside the chunk.
        for (int i = 0; i < 7; i++)
            add_byte(i[0] ? 8'h46 : 8'h66, 1'b0);
        add_byte(CH_LF,   1'b0);
        add_byte(8'h5A,   1'b0);
        add_byte(8'hA5,   1'b1);
        wait_drained();

        // Random: receiver mostly stalled.
        src_idle_pct = 33;
        snk_idle_pct = 67;
        fill_random(340);
        wait_drained();

        // Random: sender mostly idle.
        src_idle_pct = 67;
        snk_idle_pct = 33;
        fill_random(340);
        wait_drained();

        // Random: full rate both ways.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        fill_random(340);
        wait_drained();

        // Let any stray result surface before the verdict.
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
src/hcbd_pkg.sv
src/hcbd_if.sv
src/hcbd_step.sv
src/http_chunked_body_decoder.sv
tb/tb.sv
